@@ src/sgr_pkg.sv @@
// ============================================================================
// sgr_pkg: shared types, constants and font tables
// Beat types, queue entry type, 3x5 font ROM and glyph lookup.
// ============================================================================
package sgr_pkg;

    localparam logic [2:0] SCALE_RESET = 3'd2;
    localparam logic [2:0] MAX_SCALE   = 3'd4;
    localparam int         N_GLYPHS    = 40;
    localparam int         GLYPH_W     = $clog2(N_GLYPHS);
    localparam logic [GLYPH_W-1:0] GLYPH_BLANK = GLYPH_W'(23);
    localparam int         N_PIX       = 15;
    localparam int         PIX_W       = $clog2(N_PIX);
    localparam int         Q_DEPTH     = 2;
    localparam int         Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int         Q_CNT_W     = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [7:0]  char_code;
        logic [9:0]  pen_x;
        logic [9:0]  pen_y;
        logic [15:0] ink_color;
    } item_t;

    typedef struct packed {
        logic [10:0] rect_x;
        logic [10:0] rect_y;
        logic [2:0]  rect_side;
        logic [15:0] rect_color;
        logic        draw;
        logic [10:0] next_x;
        logic        last;
    } rect_t;

    // classified character, handed from front to back
    typedef struct packed {
        logic [N_PIX-1:0] mask;     // bit row*3+col set = font pixel on
        logic [9:0]       pen_x;
        logic [9:0]       pen_y;
        logic [15:0]      color;
        logic [2:0]       scale;
        logic [10:0]      next_x;
    } job_t;

    // row 0 first; bit 2 of a row is the left column
    typedef logic [0:4][2:0] glyph_t;

    localparam glyph_t GLYPH_ROM [N_GLYPHS] = '{
        {3'd7,3'd5,3'd5,3'd5,3'd7}, {3'd2,3'd6,3'd2,3'd2,3'd7},
        {3'd7,3'd1,3'd7,3'd4,3'd7}, {3'd7,3'd1,3'd7,3'd1,3'd7},
        {3'd5,3'd5,3'd7,3'd1,3'd1}, {3'd7,3'd4,3'd7,3'd1,3'd7},
        {3'd7,3'd4,3'd7,3'd5,3'd7}, {3'd7,3'd1,3'd1,3'd1,3'd1},
        {3'd7,3'd5,3'd7,3'd5,3'd7}, {3'd7,3'd5,3'd7,3'd1,3'd7},
        {3'd7,3'd5,3'd7,3'd5,3'd5}, // A
        {3'd7,3'd4,3'd7,3'd4,3'd7}, // E
        {3'd7,3'd4,3'd5,3'd5,3'd7}, // G
        {3'd5,3'd5,3'd7,3'd5,3'd5}, // H
        {3'd7,3'd2,3'd2,3'd2,3'd7}, // I
        {3'd5,3'd7,3'd7,3'd5,3'd5}, // M
        {3'd7,3'd5,3'd5,3'd5,3'd7}, // O
        {3'd7,3'd5,3'd7,3'd4,3'd4}, // P
        {3'd7,3'd5,3'd6,3'd5,3'd5}, // R
        {3'd7,3'd4,3'd7,3'd1,3'd7}, // S
        {3'd5,3'd5,3'd5,3'd5,3'd7}, // U
        {3'd5,3'd5,3'd5,3'd5,3'd2}, // V
        {3'd6,3'd5,3'd5,3'd5,3'd6}, // D
        {3'd0,3'd0,3'd0,3'd0,3'd0}, // space
        {3'd6,3'd5,3'd6,3'd5,3'd6}, // B
        {3'd3,3'd4,3'd4,3'd4,3'd3}, // C
        {3'd5,3'd5,3'd6,3'd5,3'd5}, // K
        {3'd4,3'd4,3'd4,3'd4,3'd7}, // L
        {3'd7,3'd2,3'd2,3'd2,3'd2}, // T
        {3'd5,3'd1,3'd2,3'd4,3'd5}, // percent
        {3'd1,3'd2,3'd4,3'd2,3'd1}, // less-than
        {3'd4,3'd2,3'd1,3'd2,3'd4}, // greater-than
        {3'd6,3'd7,3'd7,3'd5,3'd5}, // N
        {3'd7,3'd4,3'd6,3'd4,3'd4}, // F
        {3'd1,3'd1,3'd1,3'd5,3'd7}, // J
        {3'd7,3'd5,3'd7,3'd3,3'd1}, // Q
        {3'd5,3'd5,3'd7,3'd7,3'd5}, // W
        {3'd5,3'd5,3'd2,3'd5,3'd5}, // X
        {3'd5,3'd5,3'd2,3'd2,3'd2}, // Y
        {3'd0,3'd0,3'd7,3'd0,3'd0}  // dash
    };

    function automatic logic [GLYPH_W-1:0] char_to_glyph(input logic [7:0] code);
        logic [GLYPH_W-1:0] idx;
        idx = GLYPH_BLANK;
        if (code >= 8'h30 && code <= 8'h39)
        begin
            idx = GLYPH_W'(code - 8'h30);
        end
        else
        begin
            case (code)
                8'h41: idx = GLYPH_W'(10);  // A
                8'h45: idx = GLYPH_W'(11);  // E
                8'h47: idx = GLYPH_W'(12);  // G
                8'h48: idx = GLYPH_W'(13);  // H
                8'h49: idx = GLYPH_W'(14);  // I
                8'h4D: idx = GLYPH_W'(15);  // M
                8'h4F: idx = GLYPH_W'(16);  // O
                8'h50: idx = GLYPH_W'(17);  // P
                8'h52: idx = GLYPH_W'(18);  // R
                8'h53: idx = GLYPH_W'(19);  // S
                8'h55: idx = GLYPH_W'(20);  // U
                8'h56: idx = GLYPH_W'(21);  // V
                8'h44: idx = GLYPH_W'(22);  // D
                8'h42: idx = GLYPH_W'(24);  // B
                8'h43: idx = GLYPH_W'(25);  // C
                8'h4B: idx = GLYPH_W'(26);  // K
                8'h4C: idx = GLYPH_W'(27);  // L
                8'h54: idx = GLYPH_W'(28);  // T
                8'h25: idx = GLYPH_W'(29);  // percent
                8'h3C: idx = GLYPH_W'(30);  // less-than
                8'h3E: idx = GLYPH_W'(31);  // greater-than
                8'h4E: idx = GLYPH_W'(32);  // N
                8'h46: idx = GLYPH_W'(33);  // F
                8'h4A: idx = GLYPH_W'(34);  // J
                8'h51: idx = GLYPH_W'(35);  // Q
                8'h57: idx = GLYPH_W'(36);  // W
                8'h58: idx = GLYPH_W'(37);  // X
                8'h59: idx = GLYPH_W'(38);  // Y
                8'h2D: idx = GLYPH_W'(39);  // dash
                default: idx = GLYPH_BLANK;
            endcase
        end
        return idx;
    endfunction

    // flatten a glyph into scan order: bit row*3+col
    function automatic logic [N_PIX-1:0] glyph_mask(input glyph_t g);
        logic [N_PIX-1:0] m;
        m = '0;
        for (int r = 0; r < 5; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                m[r*3+c] = g[r][2-c];
            end
        end
        return m;
    endfunction

endpackage

@@ src/sgr_front.sv @@
// ============================================================================
// sgr_front: command intake and classification
// Holds the scale register, looks up the glyph and builds a job per beat.
// ============================================================================
module sgr_front
    import sgr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_data,
    input  item_t       item,
    output job_t        job
);

    logic [2:0] scale_reg;
    logic [2:0] scale_eff;
    glyph_t     glyph;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            scale_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (scale_reg == 3'd0)
        begin
            scale_eff = 3'd1;
        end
        else if (scale_reg > MAX_SCALE)
        begin
            scale_eff = MAX_SCALE;
        end
        else
        begin
            scale_eff = scale_reg;
        end
    end

    assign glyph = GLYPH_ROM[char_to_glyph(item.char_code)];

    always_comb
    begin
        job.mask   = glyph_mask(glyph);
        job.pen_x  = item.pen_x;
        job.pen_y  = item.pen_y;
        job.color  = item.ink_color;
        job.scale  = scale_eff;
        job.next_x = 11'(item.pen_x) + 11'({scale_eff, 2'b00});
    end

endmodule

@@ src/sgr_queue.sv @@
// ============================================================================
// sgr_queue: job queue between front and back
// Small register FIFO; full drives busy toward the command side.
// ============================================================================
module sgr_queue
    import sgr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic not_empty,
    output logic full
);

    job_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ src/sgr_back.sv @@
// ============================================================================
// sgr_back: square emitter
// Walks the set pixels of one job, one square per cycle, then the terminator.
// ============================================================================
module sgr_back
    import sgr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  job_t  head,
    input  logic  not_empty,
    output logic  pop,
    output rect_t rect,
    output logic  rect_strobe
);

    logic             active_reg, active_next;
    job_t             cur_reg, cur_next;
    logic [N_PIX-1:0] mask_reg, mask_next;
    rect_t            rect_reg, rect_next;
    logic             strobe_reg, strobe_next;

    logic [PIX_W-1:0] pix_idx;
    logic [2:0]       row;
    logic [1:0]       col;
    logic             any_pix;
    logic             done;
    logic [4:0]       col_off;
    logic [4:0]       row_off;

    // lowest set pixel is next in scan order
    always_comb
    begin
        pix_idx = '0;
        row     = '0;
        col     = '0;
        for (int r = 4; r >= 0; r--)
        begin
            for (int c = 2; c >= 0; c--)
            begin
                if (mask_reg[r*3+c])
                begin
                    pix_idx = PIX_W'(r*3+c);
                    row     = 3'(r);
                    col     = 2'(c);
                end
            end
        end
    end

    assign any_pix = |mask_reg;
    assign col_off = 5'(col) * 5'(cur_reg.scale);
    assign row_off = 5'(row) * 5'(cur_reg.scale);
    assign done    = active_reg && !any_pix;
    assign pop     = (!active_reg || done) && not_empty;

    always_comb
    begin
        active_next = active_reg;
        cur_next    = cur_reg;
        mask_next   = mask_reg;
        rect_next   = rect_reg;
        strobe_next = active_reg;

        if (active_reg)
        begin
            rect_next.next_x = cur_reg.next_x;
            if (any_pix)
            begin
                rect_next.rect_x     = 11'(cur_reg.pen_x) + 11'(col_off);
                rect_next.rect_y     = 11'(cur_reg.pen_y) + 11'(row_off);
                rect_next.rect_side  = cur_reg.scale;
                rect_next.rect_color = cur_reg.color;
                rect_next.draw       = 1'b1;
                rect_next.last       = 1'b0;
                mask_next            = mask_reg & ~(N_PIX'(1) << pix_idx);
            end
            else
            begin
                rect_next.rect_x     = '0;
                rect_next.rect_y     = '0;
                rect_next.rect_side  = '0;
                rect_next.rect_color = '0;
                rect_next.draw       = 1'b0;
                rect_next.last       = 1'b1;
                active_next          = 1'b0;
            end
        end

        // next job loads in the same cycle the terminator goes out
        if (pop)
        begin
            cur_next    = head;
            mask_next   = head.mask;
            active_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        mask_reg <= mask_next;
        rect_reg <= rect_next;
    end

    assign rect        = rect_reg;
    assign rect_strobe = strobe_reg;

endmodule

@@ src/scaled_glyph_rasterizer.sv @@
// ============================================================================
// scaled_glyph_rasterizer: 3x5 font character generator
// Turns one character command into scaled pixel squares plus a terminator.
// ============================================================================
//  channel  | signals                       | handshake
//  ---------+-------------------------------+----------------------------------
//  command  | start, busy, item             | beat taken when start && !busy
//  config   | cfg_valid, cfg_ready, cfg_data| write when cfg_valid && cfg_ready
//  result   | rect_strobe, rect             | one strobe per beat, no backpressure
//
// A character yields a square per set font pixel, then a terminator; the
// emitter's one-square-per-cycle walk sets the rate. A two-entry job queue
// lets commands be taken while the emitter works; busy is high only when
// that queue is full. Reset is asynchronous, active low, and sets the
// scale to 2.
module scaled_glyph_rasterizer
    import sgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  item_t      item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_data,
    output rect_t      rect,
    output logic       rect_strobe
);

    job_t front_job;
    job_t head;
    logic push;
    logic pop;
    logic not_empty;
    logic full;

    assign cfg_ready = 1'b1;
    assign busy      = full;
    assign push      = start && !full;

    sgr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .item      (item),
        .job       (front_job)
    );

    sgr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (front_job),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .full      (full)
    );

    sgr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .not_empty   (not_empty),
        .pop         (pop),
        .rect        (rect),
        .rect_strobe (rect_strobe)
    );

endmodule
